### design/nsv_pkg.sv
// Shared types and constants for the NMEA sentence validator.
// No dependencies; imported by every module of the block.
package nsv_pkg;

    localparam int MAX_LINE_DEF = 128;
    localparam int QUEUE_DEPTH  = 2;

    // Line status codes
    localparam logic [1:0] ST_IGNORED  = 2'd0;
    localparam logic [1:0] ST_BAD_SUM  = 2'd1;
    localparam logic [1:0] ST_BAD_TYPE = 2'd2;
    localparam logic [1:0] ST_VALID    = 2'd3;

    // Sentence kinds
    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_GGA   = 2'd1;
    localparam logic [1:0] KIND_GSV   = 2'd2;
    localparam logic [1:0] KIND_RMC   = 2'd3;

    localparam logic [23:0] TXT_GGA = 24'h474741;
    localparam logic [23:0] TXT_GSV = 24'h475356;
    localparam logic [23:0] TXT_RMC = 24'h524D43;

    // One framed line handed from front to back
    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] text;
        logic [1:0]  len;
        logic [31:0] bytes;
    } t_line;

endpackage

### design/nsv_front.sv
// Front end: frames received bytes into lines, runs the checksum and type scan.
// Depends on nsv_pkg; pushes one t_line per LF into the line queue.
module nsv_front
    import nsv_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_byte_valid,
    output logic        o_byte_ready,
    input  logic [7:0]  i_byte,
    input  logic        i_full,
    output logic        o_push,
    output t_line       o_line
);

    localparam int LEN_W = $clog2(MAX_LINE + 1);
    localparam logic [LEN_W-1:0] MAX_L = LEN_W'(MAX_LINE);

    localparam logic [2:0] PH_SKIP   = 3'd0;
    localparam logic [2:0] PH_BODY   = 3'd1;
    localparam logic [2:0] PH_DIGITS = 3'd2;
    localparam logic [2:0] PH_TAIL   = 3'd3;
    localparam logic [2:0] PH_IGNORE = 3'd4;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    logic [LEN_W-1:0] r_len, n_len;
    logic [2:0]       r_phase, n_phase;
    logic [7:0]       r_xor, n_xor;
    logic             r_hex_cnt, n_hex_cnt;
    logic [7:0]       r_hex, n_hex;
    logic             r_hex_err, n_hex_err;
    logic             r_first, n_first;
    logic [23:0]      r_type, n_type;
    logic [1:0]       r_tcnt, n_tcnt;
    logic [31:0]      r_bytes, n_bytes;

    logic             acc;
    logic [23:0]      masked;
    logic             type_ok;

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C;
    endfunction

    function automatic logic is_type_char(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    // bit 4 flags a non-hex character
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39)      v = {1'b0, 4'(c - 8'h30)};
        else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
        else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
        return v;
    endfunction

    assign acc          = i_byte_valid && !i_full;
    assign o_byte_ready = !i_full;

    // Type characters that actually belong to the line
    always_comb begin
        case (r_tcnt)
            2'd3:    masked = r_type;
            2'd2:    masked = {8'h00, r_type[15:0]};
            2'd1:    masked = {16'h0000, r_type[7:0]};
            default: masked = 24'h0;
        endcase
        type_ok = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (i < int'(r_tcnt) && !is_type_char(masked[8*i +: 8])) type_ok = 1'b0;
        end
    end

    // Result for a line ending on this beat
    always_comb begin
        o_line.bytes  = r_bytes + 32'd1;
        o_line.status = ST_IGNORED;
        o_line.text   = 24'h0;
        o_line.len    = 2'd0;
        if (r_phase == PH_SKIP || r_phase == PH_IGNORE) begin
            o_line.status = ST_IGNORED;
        end else if (r_phase != PH_TAIL || r_hex_err || r_hex != r_xor) begin
            o_line.status = ST_BAD_SUM;
        end else if (r_tcnt == 2'd0) begin
            o_line.status = ST_IGNORED;
        end else begin
            o_line.text   = masked;
            o_line.len    = r_tcnt;
            o_line.status = type_ok ? ST_VALID : ST_BAD_TYPE;
        end
    end

    always_comb begin
        logic [4:0] hv;
        hv        = hex_val(i_byte);
        n_len     = r_len;
        n_phase   = r_phase;
        n_xor     = r_xor;
        n_hex_cnt = r_hex_cnt;
        n_hex     = r_hex;
        n_hex_err = r_hex_err;
        n_first   = r_first;
        n_type    = r_type;
        n_tcnt    = r_tcnt;
        n_bytes   = r_bytes;
        o_push    = 1'b0;
        if (acc) begin
            n_bytes = r_bytes + 32'd1;
            if (i_byte != CH_CR) begin
                if (i_byte != CH_LF && r_len < MAX_L) begin
                    n_len = r_len + LEN_W'(1);
                    unique case (r_phase)
                        PH_SKIP: begin
                            if (!is_blank(i_byte))
                                n_phase = (i_byte == CH_DOLLAR) ? PH_BODY : PH_IGNORE;
                        end
                        PH_BODY: begin
                            if (i_byte == CH_STAR) begin
                                n_phase = PH_DIGITS;
                            end else begin
                                n_xor = r_xor ^ i_byte;
                                if (r_first) begin
                                    if (i_byte == CH_COMMA) begin
                                        n_first = 1'b0;
                                    end else begin
                                        n_type = {r_type[15:0], i_byte};
                                        if (r_tcnt != 2'd3) n_tcnt = r_tcnt + 2'd1;
                                    end
                                end
                            end
                        end
                        PH_DIGITS: begin
                            if (hv[4]) n_hex_err = 1'b1;
                            else       n_hex = {r_hex[3:0], hv[3:0]};
                            n_hex_cnt = 1'b1;
                            if (r_hex_cnt) n_phase = PH_TAIL;
                        end
                        default: ;
                    endcase
                end else begin
                    // LF closes the line; an overlong line is dropped with this beat
                    o_push    = (i_byte == CH_LF);
                    n_len     = '0;
                    n_phase   = PH_SKIP;
                    n_xor     = 8'h0;
                    n_hex_cnt = 1'b0;
                    n_hex     = 8'h0;
                    n_hex_err = 1'b0;
                    n_first   = 1'b1;
                    n_type    = 24'h0;
                    n_tcnt    = 2'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_phase   <= PH_SKIP;
            r_xor     <= 8'h0;
            r_hex_cnt <= 1'b0;
            r_hex     <= 8'h0;
            r_hex_err <= 1'b0;
            r_first   <= 1'b1;
            r_type    <= 24'h0;
            r_tcnt    <= 2'd0;
            r_bytes   <= 32'h0;
        end else begin
            r_len     <= n_len;
            r_phase   <= n_phase;
            r_xor     <= n_xor;
            r_hex_cnt <= n_hex_cnt;
            r_hex     <= n_hex;
            r_hex_err <= n_hex_err;
            r_first   <= n_first;
            r_type    <= n_type;
            r_tcnt    <= n_tcnt;
            r_bytes   <= n_bytes;
        end
    end

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= MAX_L)
        else $error("line length past limit");

    a_digits_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hex_cnt |-> (r_phase == PH_DIGITS || r_phase == PH_TAIL))
        else $error("hex digit count outside checksum phase");

endmodule

### design/nsv_queue.sv
// Short line queue between front and back so each side can stall alone.
// Depends on nsv_pkg for t_line and QUEUE_DEPTH.
module nsv_queue
    import nsv_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_line i_line,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_line o_line
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_line              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic               do_push, do_pop;

    assign o_full  = r_cnt == CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_line  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push)
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            if (do_pop)
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            r_cnt <= r_cnt + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(QUEUE_DEPTH))
        else $error("queue overfilled");

endmodule

### design/nsv_back.sv
// Back end: classifies the sentence kind, keeps the good/bad counters and
// holds the output register. Depends on nsv_pkg.
module nsv_back
    import nsv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_line_valid,
    input  t_line       i_line,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [1:0]  o_kind,
    output logic [23:0] o_text,
    output logic [1:0]  o_len,
    output logic [31:0] o_good,
    output logic [31:0] o_bad,
    output logic [31:0] o_bytes
);

    logic        r_valid;
    logic [1:0]  r_status, r_kind, r_len;
    logic [23:0] r_text;
    logic [31:0] r_good, r_bad, r_bytes;
    logic [1:0]  kind;

    assign o_pop = i_line_valid && (!r_valid || i_ready);

    always_comb begin
        kind = KIND_OTHER;
        if (i_line.status == ST_VALID && i_line.len == 2'd3) begin
            if (i_line.text == TXT_GGA)      kind = KIND_GGA;
            else if (i_line.text == TXT_GSV) kind = KIND_GSV;
            else if (i_line.text == TXT_RMC) kind = KIND_RMC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_good  <= 32'h0;
            r_bad   <= 32'h0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                if (i_line.status == ST_VALID) r_good <= r_good + 32'd1;
                if (i_line.status == ST_BAD_SUM || i_line.status == ST_BAD_TYPE)
                    r_bad <= r_bad + 32'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status <= i_line.status;
            r_kind   <= kind;
            r_text   <= i_line.text;
            r_len    <= i_line.len;
            r_bytes  <= i_line.bytes;
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_kind   = r_kind;
    assign o_text   = r_text;
    assign o_len    = r_len;
    assign o_good   = r_good;
    assign o_bad    = r_bad;
    assign o_bytes  = r_bytes;

    a_good_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_line.status == ST_VALID |=> r_good == $past(r_good) + 32'd1)
        else $error("good counter missed a valid sentence");

    a_counters_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_pop |=> $stable(r_good) && $stable(r_bad))
        else $error("counter moved without a line");

    a_kind_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_status != ST_VALID |-> r_kind == KIND_OTHER)
        else $error("kind set on a non-valid sentence");

endmodule

### design/nmea_sentence_validator_top.sv
// NMEA sentence validator: takes one received character per beat and returns
// one result beat per LF. The front scanner accepts a byte every cycle while the
// line queue is not full. A line result passes a two-entry line queue and from
// there is loaded into the output register, which it leaves once accepted.
// Sustained rate is one byte per cycle while the queue has room. Every input byte
// stalls while the queue is full, i.e. when a held result sits in the output
// register with two more line results queued behind it.
// Depends on nsv_pkg, nsv_front, nsv_queue and nsv_back.
module nmea_sentence_validator_top
    import nsv_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,  // [7:0] rx_byte
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [1:0] line_status, [3:2] sentence_kind, [27:4] type_text, [29:28] type_length,
    // [61:30] good_count, [93:62] bad_count, [125:94] bytes_seen, [127:126] zero
    output logic [127:0] o_m_axis_tdata
);

    logic        push, full, pop, q_valid;
    t_line       f_line, q_line;
    logic [1:0]  status, kind, len;
    logic [23:0] text;
    logic [31:0] good, bad, bytes;

    nsv_front #(.MAX_LINE(MAX_LINE)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (i_s_axis_tvalid),
        .o_byte_ready (o_s_axis_tready),
        .i_byte       (i_s_axis_tdata),
        .i_full       (full),
        .o_push       (push),
        .o_line       (f_line)
    );

    nsv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_line  (f_line),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_line  (q_line)
    );

    nsv_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_line_valid (q_valid),
        .i_line       (q_line),
        .o_pop        (pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_status     (status),
        .o_kind       (kind),
        .o_text       (text),
        .o_len        (len),
        .o_good       (good),
        .o_bad        (bad),
        .o_bytes      (bytes)
    );

    assign o_m_axis_tdata = {2'b00, bytes, bad, good, len, text, kind, status};

endmodule

### tb/nmea_sentence_validator_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for nmea_sentence_validator_top: streams NMEA-style lines in byte beats
// and checks every line result against an in-bench scanner. Depends on nsv_pkg and the design.
module nmea_sentence_validator_top_tb;
    import nsv_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 20;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    typedef enum logic [2:0] {
        SCAN_BLANKS, SCAN_BODY, SCAN_SUM, SCAN_TAIL, SCAN_DROP
    } t_scan_phase;

    typedef enum int {FLAW_NONE, FLAW_SUM, FLAW_DIGIT, FLAW_NOSTAR, FLAW_SHORT} t_flaw;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  kind;
        logic [23:0] text;
        logic [1:0]  len;
        logic [31:0] good;
        logic [31:0] bad;
        logic [31:0] bytes;
    } t_line_report;

    logic         i_clk    = 1'b0;
    logic         i_rst_n  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [7:0]   s_tdata  = 8'h00;   // [7:0] rx_byte
    logic         s_tready;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // [1:0] status, [3:2] kind, [27:4] type text, [29:28] type length,
    // [61:30] good, [93:62] bad, [125:94] bytes seen, [127:126] zero
    logic [127:0] m_tdata;

    nmea_sentence_validator_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // scanner state
    logic [7:0]  ln_len;
    t_scan_phase ln_phase;
    logic [7:0]  sum_acc;
    logic [1:0]  sum_digits;
    logic [7:0]  sum_value;
    bit          sum_bad;
    bit          first_field;
    logic [23:0] type_sr;
    logic [1:0]  type_cnt;
    logic [31:0] good_total;
    logic [31:0] bad_total;
    logic [31:0] byte_total;

    logic [7:0]   rx_pending[$];
    t_line_report line_reports[$];
    t_line_report drv_rep;
    t_line_report chk_want;

    int send_idle_pct = 10;
    int recv_idle_pct = 64;
    bit hold_req      = 1'b0;
    bit hold_done     = 1'b0;
    int hold_left     = 0;
    int stall_cycles  = 0;
    int queued_bytes  = 0;
    int bytes_taken   = 0;
    int lines_checked = 0;
    int mismatches    = 0;
    int status_seen[4];
    int kind_seen[4];

    function automatic void restart_line();
        ln_len      = '0;
        ln_phase    = SCAN_BLANKS;
        sum_acc     = '0;
        sum_digits  = '0;
        sum_value   = '0;
        sum_bad     = 1'b0;
        first_field = 1'b1;
        type_sr     = '0;
        type_cnt    = '0;
    endfunction

    // Advances the scanner by one byte; returns 1 with the line report on LF.
    function automatic bit scan_byte(input logic [7:0] c, output t_line_report r);
        logic [7:0]  d;
        logic [23:0] txt;
        bit          chars_ok;
        r = '0;
        byte_total++;
        if (c == CH_CR)
            return 1'b0;
        if (c != CH_LF) begin
            if (ln_len < MAX_LINE_DEF) begin
                ln_len++;
                case (ln_phase)
                    SCAN_BLANKS: begin
                        if (!(c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF))
                            ln_phase = (c == CH_DOLLAR) ? SCAN_BODY : SCAN_DROP;
                    end
                    SCAN_BODY: begin
                        if (c == CH_STAR) begin
                            ln_phase = SCAN_SUM;
                        end else begin
                            sum_acc ^= c;
                            if (first_field) begin
                                if (c == CH_COMMA) begin
                                    first_field = 1'b0;
                                end else begin
                                    type_sr = {type_sr[15:0], c};
                                    if (type_cnt != 2'd3)
                                        type_cnt++;
                                end
                            end
                        end
                    end
                    SCAN_SUM: begin
                        if (c >= "0" && c <= "9")
                            d = c - "0";
                        else if (c >= "A" && c <= "F")
                            d = c - "A" + 8'd10;
                        else if (c >= "a" && c <= "f")
                            d = c - "a" + 8'd10;
                        else begin
                            d = '0;
                            sum_bad = 1'b1;
                        end
                        if (!sum_bad)
                            sum_value = {sum_value[3:0], d[3:0]};
                        sum_digits++;
                        if (sum_digits == 2'd2)
                            ln_phase = SCAN_TAIL;
                    end
                    default: ;
                endcase
            end else begin
                // full line: this byte is dropped and scanning restarts
                restart_line();
            end
            return 1'b0;
        end

        if (ln_phase == SCAN_BLANKS || ln_phase == SCAN_DROP) begin
            r.status = ST_IGNORED;
        end else if (ln_phase != SCAN_TAIL || sum_bad || sum_value != sum_acc) begin
            r.status = ST_BAD_SUM;
            bad_total++;
        end else if (type_cnt == 2'd0) begin
            r.status = ST_IGNORED;
        end else begin
            case (type_cnt)
                2'd1:    txt = type_sr & 24'h0000FF;
                2'd2:    txt = type_sr & 24'h00FFFF;
                default: txt = type_sr;
            endcase
            chars_ok = 1'b1;
            for (int i = 0; i < type_cnt; i++) begin
                d = txt[8*i +: 8];
                if (!((d >= "A" && d <= "Z") || (d >= "0" && d <= "9")))
                    chars_ok = 1'b0;
            end
            r.text = txt;
            r.len  = type_cnt;
            if (!chars_ok) begin
                r.status = ST_BAD_TYPE;
                bad_total++;
            end else begin
                r.status = ST_VALID;
                good_total++;
                r.kind = KIND_OTHER;
                if (type_cnt == 2'd3) begin
                    if (txt == TXT_GGA)
                        r.kind = KIND_GGA;
                    else if (txt == TXT_GSV)
                        r.kind = KIND_GSV;
                    else if (txt == TXT_RMC)
                        r.kind = KIND_RMC;
                end
            end
        end
        r.good  = good_total;
        r.bad   = bad_total;
        r.bytes = byte_total;
        restart_line();
        return 1'b1;
    endfunction

    // ---------------- stimulus helpers ----------------
    task automatic put_byte(input logic [7:0] b);
        rx_pending.push_back(b);
        queued_bytes++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    task automatic put_blanks(input int n);
        repeat (n) begin
            case ($urandom_range(0, 3))
                0:       put_byte(CH_SPACE);
                1:       put_byte(CH_TAB);
                2:       put_byte(CH_VT);
                default: put_byte(CH_FF);
            endcase
        end
    endtask

    // any byte but LF and '*'; CR is allowed and skipped by the checksum
    function automatic logic [7:0] field_char();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0:       c = CH_COMMA;
            1:       c = 8'($urandom_range(0, 255));
            default: c = 8'($urandom_range(8'h20, 8'h7E));
        endcase
        if (c == CH_LF || c == CH_STAR)
            c = ".";
        return c;
    endfunction

    function automatic logic [7:0] type_char();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range("0", "9"));
        return 8'($urandom_range("A", "Z"));
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
            return "0" + n;
        return (lower ? "a" : "A") + n - 8'd10;
    endfunction

    function automatic logic [7:0] bad_digit();
        case ($urandom_range(0, 5))
            0:       return "+";
            1:       return "-";
            2:       return CH_SPACE;
            3:       return "G";
            4:       return "g";
            default: return 8'($urandom_range(8'h80, 8'hFF));
        endcase
    endfunction

    function automatic string random_head();
        string s;
        int    n;
        case ($urandom_range(0, 5))
            0: s = $sformatf("%c%cGGA", type_char(), type_char());
            1: s = $sformatf("%c%cGSV", type_char(), type_char());
            2: s = $sformatf("%c%cRMC", type_char(), type_char());
            default: begin
                s = "";
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    s = $sformatf("%s%c", s, type_char());
            end
        endcase
        return {s, ","};
    endfunction

    // three type characters with one that is not uppercase or a digit
    function automatic string spoiled_head();
        logic [7:0] t[3];
        for (int i = 0; i < 3; i++)
            t[i] = type_char();
        case ($urandom_range(0, 2))
            0:       t[$urandom_range(0, 2)] = 8'($urandom_range("a", "z"));
            1:       t[$urandom_range(0, 2)] = 8'($urandom_range(8'h80, 8'hFF));
            default: t[$urandom_range(0, 2)] = 8'($urandom_range(8'h3A, 8'h40));
        endcase
        return $sformatf("GP%c%c%c,", t[0], t[1], t[2]);
    endfunction

    // '$', head, random field chars, star and checksum (flawed as asked), tail, optional CR, LF
    task automatic put_sentence(input string head, input int nfields, input t_flaw flaw,
                                input logic [7:0] spoil, input int tail);
        logic [7:0] body[$];
        logic [7:0] acc;
        bit         lower;
        bit         first_bad;
        acc       = '0;
        lower     = ($urandom_range(0, 1) == 1);
        first_bad = (flaw == FLAW_DIGIT) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < head.len(); i++)
            body.push_back(head[i]);
        repeat (nfields) body.push_back(field_char());
        put_byte(CH_DOLLAR);
        foreach (body[i]) begin
            put_byte(body[i]);
            if (body[i] != CH_CR)
                acc ^= body[i];
        end
        if (flaw == FLAW_SUM)
            acc ^= 8'($urandom_range(1, 255));
        if (flaw != FLAW_NOSTAR) begin
            put_byte(CH_STAR);
            put_byte(first_bad ? spoil : hex_char(acc[7:4], lower));
            if (flaw == FLAW_DIGIT && !first_bad)
                put_byte(spoil);
            else if (flaw != FLAW_SHORT)
                put_byte(hex_char(acc[3:0], lower));
        end
        repeat (tail) put_byte(field_char());
        if ($urandom_range(0, 1))
            put_byte(CH_CR);
        put_byte(CH_LF);
    endtask

    task automatic put_random_line();
        int         pick;
        int         tail;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        tail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if (pick < 85 && $urandom_range(0, 3) == 0)
            put_blanks($urandom_range(1, 3));
        if (pick < 58) begin
            put_sentence(random_head(), $urandom_range(0, 8), FLAW_NONE, 8'h00, tail);
        end else if (pick < 64) begin
            put_sentence(random_head(), $urandom_range(0, 6), FLAW_SUM, 8'h00, tail);
        end else if (pick < 70) begin
            put_sentence(random_head(), $urandom_range(0, 6), FLAW_DIGIT, bad_digit(), tail);
        end else if (pick < 76) begin
            put_sentence(spoiled_head(), $urandom_range(0, 6), FLAW_NONE, 8'h00, tail);
        end else if (pick < 79) begin
            put_sentence(random_head(), $urandom_range(0, 6), FLAW_NOSTAR, 8'h00, 0);
        end else if (pick < 82) begin
            put_sentence(random_head(), $urandom_range(0, 6), FLAW_SHORT, 8'h00, 0);
        end else if (pick < 85) begin
            put_sentence(",", $urandom_range(0, 6), FLAW_NONE, 8'h00, tail);
        end else if (pick < 90) begin
            // line not led by '$', or blanks only
            if ($urandom_range(0, 2) == 0) begin
                put_blanks($urandom_range(1, 4));
            end else begin
                c = 8'($urandom_range(8'h21, 8'h7E));
                put_byte(c == CH_DOLLAR ? "#" : c);
                repeat ($urandom_range(0, 8)) put_byte(field_char());
            end
            put_byte(CH_LF);
        end else begin
            repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)));
            put_byte(CH_LF);
        end
    endtask

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                bytes_taken++;
                if (scan_byte(s_tdata, drv_rep))
                    line_reports.push_back(drv_rep);
            end
            if (!s_tvalid || s_tready) begin
                if (rx_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= rx_pending.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- result side ready, with one long hold ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ---------------- monitor ----------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: line %0d %s expected %0h actual %0h",
                     $time, lines_checked, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            lines_checked++;
            if (line_reports.size() == 0) begin
                mismatches++;
                $display("%0t: result beat with none expected, expected nothing actual %h",
                         $time, m_tdata);
            end else begin
                chk_want = line_reports.pop_front();
                check_field("line_status", 32'(chk_want.status), 32'(m_tdata[1:0]));
                check_field("sentence_kind", 32'(chk_want.kind), 32'(m_tdata[3:2]));
                check_field("type_text", 32'(chk_want.text), 32'(m_tdata[27:4]));
                check_field("type_length", 32'(chk_want.len), 32'(m_tdata[29:28]));
                check_field("good_count", chk_want.good, m_tdata[61:30]);
                check_field("bad_count", chk_want.bad, m_tdata[93:62]);
                check_field("bytes_seen", chk_want.bytes, m_tdata[125:94]);
                check_field("pad", 32'd0, 32'(m_tdata[127:126]));
                status_seen[chk_want.status]++;
                if (chk_want.status == ST_VALID)
                    kind_seen[chk_want.kind]++;
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                     $time, stall_cycles, line_reports.size());
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ---------------- sequence ----------------
    initial begin
        int base;
        int lines;
        restart_line();
        good_total = '0;
        bad_total  = '0;
        byte_total = '0;
        foreach (status_seen[i]) status_seen[i] = 0;
        foreach (kind_seen[i]) kind_seen[i] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed lines
        put_sentence("GPGGA,1", 0, FLAW_NONE, 8'h00, 0);
        put_blanks(2);
        put_sentence("GNGSV,3", 0, FLAW_NONE, 8'h00, 2);
        put_sentence("GPRMC", 0, FLAW_NONE, 8'h00, 0);          // no comma at all
        put_sentence("P1234,", 2, FLAW_NONE, 8'h00, 0);
        put_sentence("Z,", 1, FLAW_NONE, 8'h00, 0);
        put_sentence(",A,B", 0, FLAW_NONE, 8'h00, 0);           // empty type
        put_sentence("GPgsv,", 1, FLAW_NONE, 8'h00, 0);
        put_sentence($sformatf("GP%cA,", 8'hFF), 1, FLAW_NONE, 8'h00, 0);
        put_sentence("GGA,", 2, FLAW_SUM, 8'h00, 0);
        put_sentence("GGA,", 2, FLAW_DIGIT, "+", 0);
        put_sentence("RMC,", 2, FLAW_DIGIT, "-", 0);
        put_sentence("GSV,", 2, FLAW_DIGIT, CH_SPACE, 0);
        put_sentence("GGA,", 2, FLAW_NOSTAR, 8'h00, 0);
        put_sentence("GGA,", 2, FLAW_SHORT, 8'h00, 0);
        put_blanks(3);
        put_byte(CH_LF);
        put_byte(CH_LF);
        put_text("GPGGA,1*00");
        put_byte(CH_LF);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(CH_LF);
        // one past the limit clears, then a fresh sentence follows on the same line
        repeat (129) put_byte("x");
        put_sentence("GPRMC,", 2, FLAW_NONE, 8'h00, 0);

        for (int p = 0; p < 3; p++) begin
            if (p == 1) begin
                send_idle_pct = 64;
                recv_idle_pct = 10;
            end else if (p == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            base  = queued_bytes;
            lines = 0;
            while (lines < 4 || queued_bytes - base < 40) begin
                put_random_line();
                lines++;
            end
            if (p == 2)
                hold_req = 1'b1;
            while (rx_pending.size() != 0 || s_tvalid || line_reports.size() != 0)
                @(negedge i_clk);
        end

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("Covered %0d bytes, %0d line results: %0d ignored, %0d bad sum, %0d bad type,",
                 bytes_taken, lines_checked, status_seen[ST_IGNORED], status_seen[ST_BAD_SUM],
                 status_seen[ST_BAD_TYPE]);
        $display("%0d valid (%0d GGA, %0d GSV, %0d RMC, %0d other); %0d mismatches",
                 status_seen[ST_VALID], kind_seen[KIND_GGA], kind_seen[KIND_GSV],
                 kind_seen[KIND_RMC], kind_seen[KIND_OTHER], mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
